// ===== sv/prmt_pkg.sv =====
// ----------------------------------------------------------------------------
// prmt_pkg
// Shared types and constants of the port range map table.
// ----------------------------------------------------------------------------
package prmt_pkg;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_MAP    = 2'd1;
	localparam logic [1:0] OP_UNMAP  = 2'd2;
	localparam logic [1:0] OP_GET    = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_HDL  = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_CONFLICT = 3'd3;
	localparam logic [2:0] ST_MAPPED   = 3'd4;
	localparam logic [2:0] ST_UNMAPPED = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;
	localparam logic [2:0] ST_MISMATCH = 3'd7;

	localparam logic [13:0] PORTS_MAX = 14'd8192;
	localparam logic [15:0] NO_BASE   = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  handle_out;
		logic        is_mapped;
		logic [15:0] mapped_base;
	} result_t;

endpackage

// ===== sv/prmt_ivl.sv =====
// ----------------------------------------------------------------------------
// prmt_ivl
// Sorted interval memory with a shared compare unit: binary search,
// shift up for insert, shift down for remove; each step reads one entry.
// ----------------------------------------------------------------------------
module prmt_ivl #(
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    op,
	input  logic [AW:0]   n,
	input  logic [AW:0]   cnt,
	input  logic [15:0]   lo,
	input  logic [15:0]   hi,
	input  logic [AW-1:0] hdl,
	output logic          done,
	output logic          hit,
	output logic [AW-1:0] hit_handle,
	output logic [AW:0]   pos
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CMP  = 5'b00100,
		S_MOVE = 5'b01000,
		S_WR   = 5'b10000
	} st_t;

	localparam int D = 1 << AW;

	st_t           st_q;
	logic [15:0]   first_mem [D];
	logic [15:0]   last_mem  [D];
	logic [AW-1:0] hdl_mem   [D];
	logic [AW:0]   beg_q, end_q, i_q, k_q;
	logic [15:0]   rf_q, rl_q;
	logic [AW-1:0] rh_q;
	logic          ins_q;
	logic          mv_q;
	logic [1:0]    op_q;
	logic [AW:0]   cnt_q;
	logic [15:0]   lo_q, hi_q;
	logic [AW-1:0] hdl_q;
	logic [AW:0]   km1;

	assign km1 = k_q - 1'b1;

	always_ff @(posedge clk) begin
		if (st_q == S_RD) begin
			rf_q <= first_mem[i_q[AW-1:0]];
			rl_q <= last_mem[i_q[AW-1:0]];
			rh_q <= hdl_mem[i_q[AW-1:0]];
		end
		if (st_q == S_MOVE) begin
			if (ins_q) begin
				first_mem[k_q[AW-1:0]] <= rf_q;
				last_mem[k_q[AW-1:0]]  <= rl_q;
				hdl_mem[k_q[AW-1:0]]   <= rh_q;
			end else begin
				first_mem[km1[AW-1:0]] <= rf_q;
				last_mem[km1[AW-1:0]]  <= rl_q;
				hdl_mem[km1[AW-1:0]]   <= rh_q;
			end
		end
		if (st_q == S_WR) begin
			first_mem[pos[AW-1:0]] <= lo_q;
			last_mem[pos[AW-1:0]]  <= hi_q;
			hdl_mem[pos[AW-1:0]]   <= hdl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			done  <= 1'b0;
			hit   <= 1'b0;
			pos   <= '0;
			beg_q <= '0;
			end_q <= '0;
			i_q   <= '0;
			k_q   <= '0;
			ins_q <= 1'b0;
			mv_q  <= 1'b0;
			op_q  <= '0;
			cnt_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
			hdl_q <= '0;
			hit_handle <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= op;
						cnt_q <= cnt;
						lo_q  <= lo;
						hi_q  <= hi;
						hdl_q <= hdl;
						beg_q <= '0;
						end_q <= n;
						i_q   <= n >> 1;
						hit   <= 1'b0;
						mv_q  <= 1'b0;
						if (n == '0) begin
							pos  <= '0;
							done <= (op == prmt_pkg::OP_UNMAP);
							if (op == prmt_pkg::OP_MAP) st_q <= S_WR;
						end else begin
							st_q <= S_RD;
						end
					end
				end
				S_RD: st_q <= mv_q ? S_MOVE : S_CMP;
				S_CMP: begin
					if (rl_q < lo_q) begin
						if (i_q + 1'b1 < end_q) begin
							beg_q <= i_q + 1'b1;
							i_q   <= i_q + 1'b1 + ((end_q - i_q - 1'b1) >> 1);
							st_q  <= S_RD;
						end else begin
							pos <= i_q + 1'b1;
							if (op_q == prmt_pkg::OP_MAP) begin
								ins_q <= 1'b1;
								mv_q  <= 1'b1;
								k_q   <= cnt_q;
								i_q   <= cnt_q - 1'b1;
								st_q  <= (cnt_q > i_q + 1'b1) ? S_RD : S_WR;
							end else begin
								done <= 1'b1;
								st_q <= S_IDLE;
							end
						end
					end else if (rf_q > hi_q) begin
						if (i_q > beg_q) begin
							end_q <= i_q;
							i_q   <= beg_q + ((i_q - beg_q) >> 1);
							st_q  <= S_RD;
						end else begin
							pos <= i_q;
							if (op_q == prmt_pkg::OP_MAP) begin
								ins_q <= 1'b1;
								mv_q  <= 1'b1;
								k_q   <= cnt_q;
								i_q   <= cnt_q - 1'b1;
								st_q  <= (cnt_q > i_q) ? S_RD : S_WR;
							end else begin
								done <= 1'b1;
								st_q <= S_IDLE;
							end
						end
					end else begin
						pos        <= i_q;
						hit        <= 1'b1;
						hit_handle <= rh_q;
						if (op_q == prmt_pkg::OP_UNMAP && rh_q == hdl_q &&
						    i_q + 1'b1 < cnt_q) begin
							ins_q <= 1'b0;
							mv_q  <= 1'b1;
							k_q   <= i_q + 1'b1;
							i_q   <= i_q + 1'b1;
							st_q  <= S_RD;
						end else begin
							done <= 1'b1;
							st_q <= S_IDLE;
						end
					end
				end
				S_MOVE: begin
					if (ins_q) begin
						if (k_q - 1'b1 > pos) begin
							k_q  <= k_q - 1'b1;
							i_q  <= k_q - 2'd2;
							st_q <= S_RD;
						end else begin
							st_q <= S_WR;
						end
					end else begin
						if (k_q + 1'b1 < cnt_q) begin
							k_q  <= k_q + 1'b1;
							i_q  <= k_q + 1'b1;
							st_q <= S_RD;
						end else begin
							done <= 1'b1;
							st_q <= S_IDLE;
						end
					end
				end
				S_WR: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/port_range_map_table.sv =====
// Create and get are answered from the registration table read; map and unmap
// that pass the checks also run a binary search in the interval memory (at
// most 9 probes) and, on success, shift the entries past the found position.
// Throughput: one word at a time; the next word is taken once the result is
// taken. Shifts in the interval memory set the cost.
// Reset: asynchronous, active low; clears the registration and mapping
// counts. Tables are not cleared and need no pass.
// ----------------------------------------------------------------------------
// port_range_map_table
// Registration table of port ranges and sorted table of mapped intervals.
// ----------------------------------------------------------------------------
module port_range_map_table #(
	parameter int MAX_REGS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], owner_id[9:2], handle[17:10], port_base[33:18],
	// port_count[47:34]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], handle_out[10:3], is_mapped[11], mapped_base[27:12]
	output logic [31:0] m_tdata
);

	localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int D  = 1 << AW;

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_RD   = 4'b0010,
		T_IVL  = 4'b0100,
		T_OUT  = 4'b1000
	} tst_t;

	tst_t              st_q;
	logic [1:0]        op_q;
	logic [7:0]        own_q, hdl_q;
	logic [15:0]       base_q;
	logic [13:0]       pcin_q;
	logic [AW:0]       rc_q, mc_q;
	logic [7:0]        owner_mem [D];
	logic [13:0]       pc_mem    [D];
	logic [15:0]       base_mem  [D];
	logic              mapm_mem  [D];
	logic [7:0]        r_own_q;
	logic [13:0]       r_pc_q;
	logic [15:0]       r_base_q;
	logic              r_map_q;
	prmt_pkg::result_t res_q;

	logic              iv_start, iv_done, iv_hit;
	logic [AW-1:0]     iv_hh;
	logic [AW:0]       iv_pos, iv_n;
	logic [15:0]       iv_lo, iv_hi;
	logic [16:0]       end_in;
	logic              hv;
	logic [AW-1:0]     hix;
	logic [AW-1:0]     rd_ix;

	assign hix      = AW'(hdl_q);
	assign rd_ix    = AW'(s_tdata[17:10]);
	assign hv       = (32'(hdl_q) < 32'(rc_q)) && (32'(hdl_q) < 32'(MAX_REGS));
	assign s_tready = (st_q == T_IDLE);
	assign m_tvalid = (st_q == T_OUT);
	assign m_tdata  = {4'b0, res_q.mapped_base, res_q.is_mapped,
		res_q.handle_out, res_q.status};
	assign iv_n     = (mc_q < rc_q) ? mc_q : rc_q;
	assign iv_lo    = (op_q == prmt_pkg::OP_MAP) ? base_q : r_base_q;
	assign end_in   = {1'b0, iv_lo} + {3'b0, r_pc_q} - 17'd1;
	assign iv_hi    = end_in[15:0];

	always_ff @(posedge clk) begin
		if (st_q == T_IDLE && s_tvalid) begin
			r_own_q  <= owner_mem[rd_ix];
			r_pc_q   <= pc_mem[rd_ix];
			r_base_q <= base_mem[rd_ix];
			r_map_q  <= mapm_mem[rd_ix];
		end
		if (st_q == T_RD && op_q == prmt_pkg::OP_CREATE && pcin_q != '0 &&
		    pcin_q <= prmt_pkg::PORTS_MAX && rc_q < (AW+1)'(MAX_REGS)) begin
			owner_mem[rc_q[AW-1:0]] <= own_q;
			pc_mem[rc_q[AW-1:0]]    <= pcin_q;
			base_mem[rc_q[AW-1:0]]  <= prmt_pkg::NO_BASE;
			mapm_mem[rc_q[AW-1:0]]  <= 1'b0;
		end
		if (st_q == T_IVL && iv_done) begin
			if (op_q == prmt_pkg::OP_MAP && !iv_hit) begin
				base_mem[hix] <= base_q;
				mapm_mem[hix] <= 1'b1;
			end else if (op_q == prmt_pkg::OP_UNMAP && iv_hit &&
			             iv_hh == hix) begin
				base_mem[hix] <= prmt_pkg::NO_BASE;
				mapm_mem[hix] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= T_IDLE;
			rc_q     <= '0;
			mc_q     <= '0;
			iv_start <= 1'b0;
			op_q     <= '0;
			own_q    <= '0;
			hdl_q    <= '0;
			base_q   <= '0;
			pcin_q   <= '0;
			res_q    <= '0;
		end else begin
			iv_start <= 1'b0;
			unique case (st_q)
				T_IDLE: begin
					if (s_tvalid) begin
						op_q   <= s_tdata[1:0];
						own_q  <= s_tdata[9:2];
						hdl_q  <= s_tdata[17:10];
						base_q <= s_tdata[33:18];
						pcin_q <= s_tdata[47:34];
						res_q  <= '0;
						st_q   <= T_RD;
					end
				end
				T_RD: begin
					st_q  <= T_OUT;
					if (op_q == prmt_pkg::OP_CREATE) begin
						if (pcin_q == '0 || pcin_q > prmt_pkg::PORTS_MAX)
							res_q.status <= prmt_pkg::ST_RANGE;
						else if (rc_q >= (AW+1)'(MAX_REGS))
							res_q.status <= prmt_pkg::ST_FULL;
						else begin
							res_q.handle_out <= 8'(rc_q);
							rc_q <= rc_q + 1'b1;
						end
					end else if (!hv || r_own_q != own_q) begin
						res_q.status <= prmt_pkg::ST_BAD_HDL;
					end else if (op_q == prmt_pkg::OP_MAP) begin
						if (r_pc_q == '0 || r_pc_q > prmt_pkg::PORTS_MAX)
							res_q.status <= prmt_pkg::ST_MISMATCH;
						else if ({1'b0, base_q} + {3'b0, r_pc_q} > 17'h10000)
							res_q.status <= prmt_pkg::ST_RANGE;
						else if (r_map_q)
							res_q.status <= prmt_pkg::ST_MAPPED;
						else if (mc_q >= (AW+1)'(MAX_REGS))
							res_q.status <= prmt_pkg::ST_FULL;
						else begin
							iv_start <= 1'b1;
							st_q     <= T_IVL;
						end
					end else if (op_q == prmt_pkg::OP_UNMAP) begin
						if (!r_map_q)
							res_q.status <= prmt_pkg::ST_UNMAPPED;
						else if (r_pc_q == '0 ||
						         {1'b0, r_base_q} + {3'b0, r_pc_q} > 17'h10000)
							res_q.status <= prmt_pkg::ST_MISMATCH;
						else begin
							iv_start <= 1'b1;
							st_q     <= T_IVL;
						end
					end else begin
						if (r_map_q) begin
							res_q.is_mapped   <= 1'b1;
							res_q.mapped_base <= r_base_q;
						end
					end
				end
				T_IVL: begin
					if (iv_done) begin
						st_q <= T_OUT;
						if (op_q == prmt_pkg::OP_MAP) begin
							if (iv_hit) res_q.status <= prmt_pkg::ST_CONFLICT;
							else mc_q <= mc_q + 1'b1;
						end else begin
							if (!iv_hit || iv_hh != hix)
								res_q.status <= prmt_pkg::ST_MISMATCH;
							else mc_q <= mc_q - 1'b1;
						end
					end
				end
				T_OUT: if (m_tready) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	prmt_ivl #(.AW(AW)) u_ivl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (iv_start),
		.op         (op_q),
		.n          (iv_n),
		.cnt        (mc_q),
		.lo         (iv_lo),
		.hi         (iv_hi),
		.hdl        (hix),
		.done       (iv_done),
		.hit        (iv_hit),
		.hit_handle (iv_hh),
		.pos        (iv_pos)
	);

endmodule

// ===== verif/port_range_map_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_range_map_table_tb
// Drives create, map, unmap and get words into the port range map table with
// random idling on both sides, predicts each result from a local copy of the
// registration and interval tables, and compares every result word in order.
// ----------------------------------------------------------------------------
module port_range_map_table_tb;

	localparam int NREGS = 256;
	localparam int WATCHDOG = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	port_range_map_table #(.MAX_REGS(NREGS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [13:0] port_count;
		logic [15:0] port_base;
		logic [7:0]  handle;
		logic [7:0]  owner_id;
		logic [1:0]  opcode;
	} request_t;

	int unsigned n_regs;
	logic [7:0]  own_tbl [NREGS];
	logic [13:0] cnt_tbl [NREGS];
	logic [15:0] base_tbl [NREGS];
	logic        mapped_tbl [NREGS];
	int unsigned n_ivals;
	int unsigned ival_lo [NREGS];
	int unsigned ival_hi [NREGS];
	logic [7:0]  ival_hdl [NREGS];

	request_t          pending_words[$];
	prmt_pkg::result_t expected_results[$];
	int                errors;
	bit                quiet;
	bit                hold_send;
	int                idle_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic bit find_interval(int unsigned lo, int unsigned hi,
			output int unsigned pos);
		int unsigned n, first, last_end, i;
		n = (n_ivals < n_regs) ? n_ivals : n_regs;
		first = 0;
		last_end = n;
		i = n / 2;
		pos = 0;
		if (n == 0)
			return 0;
		forever begin
			if (ival_hi[i] < lo) begin
				i++;
				if (i < last_end) first = i;
				else begin
					pos = i;
					return 0;
				end
			end else if (ival_lo[i] > hi) begin
				if (i > first) last_end = i;
				else begin
					pos = i;
					return 0;
				end
			end else begin
				pos = i;
				return 1;
			end
			i = first + (last_end - first) / 2;
		end
	endfunction

	function automatic prmt_pkg::result_t apply_request(request_t r);
		prmt_pkg::result_t res;
		int unsigned h, pc, b, pos;
		res = '0;
		h = r.handle;
		if (r.opcode == prmt_pkg::OP_CREATE) begin
			if (r.port_count == 0 || r.port_count > prmt_pkg::PORTS_MAX)
				res.status = prmt_pkg::ST_RANGE;
			else if (n_regs >= NREGS) res.status = prmt_pkg::ST_FULL;
			else begin
				own_tbl[n_regs] = r.owner_id;
				cnt_tbl[n_regs] = r.port_count;
				base_tbl[n_regs] = prmt_pkg::NO_BASE;
				mapped_tbl[n_regs] = 0;
				res.handle_out = n_regs[7:0];
				n_regs++;
			end
		end else if (h >= n_regs || own_tbl[h] != r.owner_id) begin
			res.status = prmt_pkg::ST_BAD_HDL;
		end else if (r.opcode == prmt_pkg::OP_MAP) begin
			pc = cnt_tbl[h];
			b = r.port_base;
			if (pc == 0 || pc > prmt_pkg::PORTS_MAX) res.status = prmt_pkg::ST_MISMATCH;
			else if (b + pc > 65536) res.status = prmt_pkg::ST_RANGE;
			else if (mapped_tbl[h]) res.status = prmt_pkg::ST_MAPPED;
			else if (n_ivals >= NREGS) res.status = prmt_pkg::ST_FULL;
			else if (find_interval(b, b + pc - 1, pos)) res.status = prmt_pkg::ST_CONFLICT;
			else begin
				for (int unsigned k = n_ivals; k > pos; k--) begin
					ival_lo[k] = ival_lo[k - 1];
					ival_hi[k] = ival_hi[k - 1];
					ival_hdl[k] = ival_hdl[k - 1];
				end
				ival_lo[pos] = b;
				ival_hi[pos] = b + pc - 1;
				ival_hdl[pos] = 8'(h);
				n_ivals++;
				base_tbl[h] = 16'(b);
				mapped_tbl[h] = 1;
			end
		end else if (r.opcode == prmt_pkg::OP_UNMAP) begin
			pc = cnt_tbl[h];
			b = base_tbl[h];
			if (!mapped_tbl[h]) res.status = prmt_pkg::ST_UNMAPPED;
			else if (pc == 0 || b + pc > 65536) res.status = prmt_pkg::ST_MISMATCH;
			else if (!find_interval(b, b + pc - 1, pos) || ival_hdl[pos] != h)
				res.status = prmt_pkg::ST_MISMATCH;
			else begin
				for (int unsigned k = pos; k + 1 < n_ivals; k++) begin
					ival_lo[k] = ival_lo[k + 1];
					ival_hi[k] = ival_hi[k + 1];
					ival_hdl[k] = ival_hdl[k + 1];
				end
				n_ivals--;
				base_tbl[h] = prmt_pkg::NO_BASE;
				mapped_tbl[h] = 0;
			end
		end else if (mapped_tbl[h]) begin
			res.is_mapped = 1;
			res.mapped_base = base_tbl[h];
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				expected_results.push_back(apply_request(request_t'(s_tdata)));
			if (pending_words.size() > 0 && !hold_send &&
					(quiet || $urandom_range(99) >= 12)) begin
				s_tdata <= pending_words.pop_front();
				s_tvalid <= 1;
			end else
				s_tvalid <= 0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		prmt_pkg::result_t got, want;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.handle_out = m_tdata[10:3];
				got.is_mapped = m_tdata[11];
				got.mapped_base = m_tdata[27:12];
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, 0);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.handle_out !== want.handle_out)
						report_mismatch("handle_out", got.handle_out, want.handle_out);
					if (got.is_mapped !== want.is_mapped)
						report_mismatch("is_mapped", got.is_mapped, want.is_mapped);
					if (got.mapped_base !== want.mapped_base)
						report_mismatch("mapped_base", got.mapped_base, want.mapped_base);
				end
			end
			m_tready <= quiet || $urandom_range(99) >= 12;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic request_t make_word(logic [1:0] op, logic [7:0] own,
			logic [7:0] h, logic [15:0] b, logic [13:0] c);
		request_t r;
		r.opcode = op;
		r.owner_id = own;
		r.handle = h;
		r.port_base = b;
		r.port_count = c;
		return r;
	endfunction

	// random word biased toward registered handles with their owner
	function automatic request_t random_word(int unsigned nh, logic [7:0] owners [NREGS],
			logic [13:0] counts [NREGS]);
		request_t r;
		int unsigned h;
		int unsigned sel;
		r = request_t'(48'({$urandom, $urandom}));
		sel = $urandom_range(99);
		if (nh == 0 || sel < 12) begin
			r.opcode = prmt_pkg::OP_CREATE;
			case ($urandom_range(5))
				0: r.port_count = 14'($urandom);
				1: r.port_count = prmt_pkg::PORTS_MAX;
				default: r.port_count = 14'($urandom_range(1, 64));
			endcase
			if ($urandom_range(3) == 0)
				r.port_count = 14'($urandom_range(1, prmt_pkg::PORTS_MAX));
		end else if (sel < 92) begin
			h = $urandom_range(nh - 1);
			r.handle = 8'(h);
			r.owner_id = owners[h];
			r.opcode = 2'($urandom_range(prmt_pkg::OP_MAP, prmt_pkg::OP_GET));
			if ($urandom_range(3) != 0)
				r.port_base = 16'($urandom_range(0, 2047));
			else if ($urandom_range(3) == 0)
				r.port_base = 16'(16'hFFFF - $urandom_range(counts[h]));
		end
		return r;
	endfunction

	initial begin
		logic [7:0]  owners [NREGS];
		logic [13:0] counts [NREGS];
		int unsigned nh;
		request_t r;
		errors = 0;
		quiet = 0;
		hold_send = 0;
		nh = 0;
		n_regs = 0;
		n_ivals = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed
		pending_words.push_back(make_word(prmt_pkg::OP_GET, 8'd0, 8'd0, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_CREATE, 8'd1, 8'd0, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_CREATE, 8'd1, 8'd0, 16'd0, 14'd8193));
		pending_words.push_back(make_word(prmt_pkg::OP_CREATE, 8'd1, 8'd0, 16'd0, 14'h3FFF));
		pending_words.push_back(make_word(prmt_pkg::OP_CREATE, 8'hFF, 8'hFF, 16'hFFFF,
			14'd8192));
		pending_words.push_back(make_word(prmt_pkg::OP_CREATE, 8'h00, 8'd0, 16'd0, 14'd1));
		pending_words.push_back(make_word(prmt_pkg::OP_CREATE, 8'h5A, 8'd0, 16'd0, 14'd16));
		owners[0] = 8'hFF; counts[0] = 14'd8192;
		owners[1] = 8'h00; counts[1] = 14'd1;
		owners[2] = 8'h5A; counts[2] = 14'd16;
		nh = 3;
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'hFE, 8'd0, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'hFF, 8'd3, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'hFF, 8'd0, 16'hE001, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'hFF, 8'd0, 16'hE000, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'hFF, 8'd0, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'h00, 8'd1, 16'hFFFF, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'h5A, 8'd2, 16'hFFF8, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_MAP, 8'h5A, 8'd2, 16'h1000, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_UNMAP, 8'h00, 8'd1, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_UNMAP, 8'h00, 8'd1, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_GET, 8'hFF, 8'd0, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_GET, 8'h00, 8'd1, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_UNMAP, 8'h5A, 8'd2, 16'd0, 14'd0));
		pending_words.push_back(make_word(prmt_pkg::OP_GET, 8'h5A, 8'd9, 16'd0, 14'd0));

		// random, with one long quiet stretch and one drain pause
		for (int n = 0; n < 750; n++) begin
			if (n == 300) begin
				wait (pending_words.size() == 0);
				quiet = 1;
			end
			if (n == 420) begin
				wait (pending_words.size() == 0);
				quiet = 0;
			end
			r = random_word(nh, owners, counts);
			if (r.opcode == prmt_pkg::OP_CREATE && r.port_count != 0 &&
					r.port_count <= prmt_pkg::PORTS_MAX && nh < NREGS) begin
				owners[nh] = r.owner_id;
				counts[nh] = r.port_count;
				nh++;
			end
			pending_words.push_back(r);
			if (n == 200) begin
				wait (pending_words.size() == 0);
				@(posedge clk);
				wait (!s_tvalid);
				hold_send = 1;
				wait (expected_results.size() == 0);
				@(posedge clk);
				hold_send <= 0;
			end
		end

		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (!s_tvalid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
